// File: hdl/flca_pkg.sv
// ----------------------------------------------------------------------------
// flca_pkg
// Shared constants and codes for the free list chunk allocator.
// ----------------------------------------------------------------------------
package flca_pkg;

	localparam int NUM_CHUNKS = 256;
	localparam int IDX_W      = $clog2(NUM_CHUNKS);
	localparam int LINK_W     = IDX_W + 1;
	localparam int CNT_W      = IDX_W + 1;
	localparam int WALK_LIMIT = 2 * NUM_CHUNKS + 2;
	localparam int STEP_W     = $clog2(WALK_LIMIT + 2);
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 2;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_CHUNKS);

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIND  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;

endpackage

// File: hdl/flca_req_if.sv
// ----------------------------------------------------------------------------
// flca_req_if
// Request channel of the free list chunk allocator: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface flca_req_if;
	import flca_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  chunk_index;
	logic [CNT_W-1:0]  chunk_count;
	logic [LINK_W-1:0] end_link;

	modport source (output valid, kind, chunk_index, chunk_count, end_link, input ready);
	modport sink   (input valid, kind, chunk_index, chunk_count, end_link, output ready);

endinterface

// File: hdl/flca_rsp_if.sv
// ----------------------------------------------------------------------------
// flca_rsp_if
// Result channel of the free list chunk allocator: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface flca_rsp_if;
	import flca_pkg::*;

	logic                valid;
	logic                ready;
	logic [LINK_W-1:0]   result_index;
	logic [STATUS_W-1:0] status;

	modport source (output valid, result_index, status, input ready);
	modport sink   (input valid, result_index, status, output ready);

endinterface

// File: hdl/free_list_chunk_allocator.sv
// ----------------------------------------------------------------------------
// free_list_chunk_allocator
// Singly linked free list over a pool of chunks: add block, find previous,
// allocate run. Links live in a one-port-write, one-port-read synchronous RAM.
//
// Usage:
//   req carries one request (kind, chunk_index, chunk_count, end_link); it is
//   taken when valid and ready are high at a clock edge. ready is high only
//   while the sequencer is idle, one request at a time.
//   rsp returns exactly one result (result_index, status) per request from an
//   output register, so a new request is taken while a result still waits.
//   Path from accept to rsp.valid, always ending in S_DONE and the output register:
//     rejected or trivial request          straight to S_DONE
//     add block of n chunks                S_ADD, one link write per chunk
//     find previous over k link reads      S_FIND, one link read per step
//     allocate run over k link reads       S_WALK and S_TAIL, which unlinks the run
//   Every walk reads one link per cycle from the link RAM, which sets the rate;
//   walks stop after 2*NUM_CHUNKS+2 link reads.
//   Reset clears the head to null (list empty); the link RAM is not cleared,
//   it is filled by add block. If rsp stalls, the result holds in the output
//   register and a second finished result waits in the sequencer.
// ----------------------------------------------------------------------------
module free_list_chunk_allocator (
	input  logic        clk,
	input  logic        arst_n,
	flca_req_if.sink    req,
	flca_rsp_if.source  rsp
);
	import flca_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ADD  = 6'b000010,
		S_FIND = 6'b000100,
		S_WALK = 6'b001000,
		S_TAIL = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(WALK_LIMIT);

	state_t state_q, state_d;

	logic [LINK_W-1:0]   head_q, head_d;
	logic [IDX_W-1:0]    cur_q, cur_d;
	logic [IDX_W-1:0]    first_q, first_d;
	logic [IDX_W-1:0]    prev_q, prev_d;
	logic                prev_head_q, prev_head_d;
	logic [CNT_W-1:0]    rem_q, rem_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [STEP_W-1:0]   steps_q, steps_d, steps_n;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [LINK_W-1:0]   endl_q, endl_d;
	logic [LINK_W-1:0]   res_q, res_d;
	logic [STATUS_W-1:0] st_q, st_d;

	logic                out_valid_q;
	logic [LINK_W-1:0]   out_index_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_load;

	// link RAM
	logic [LINK_W-1:0] mem [NUM_CHUNKS];
	logic [LINK_W-1:0] rd_q;
	logic [IDX_W-1:0]  raddr;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [LINK_W-1:0] wdata;

	// finish and new-candidate requests from the state decode
	logic                fin_go;
	logic [LINK_W-1:0]   fin_idx;
	logic [STATUS_W-1:0] fin_st;
	logic                cand_go;
	logic [LINK_W-1:0]   cand_f;
	logic [STEP_W-1:0]   cand_steps;
	logic [CNT_W-1:0]    cand_cnt;

	assign req.ready = (state_q == S_IDLE);
	assign steps_n   = steps_q + STEP_W'(1);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		cur_d       = cur_q;
		first_d     = first_q;
		prev_d      = prev_q;
		prev_head_d = prev_head_q;
		rem_d       = rem_q;
		cnt_d       = cnt_q;
		steps_d     = steps_q;
		idx_d       = idx_q;
		endl_d      = endl_q;
		res_d       = res_q;
		st_d        = st_q;
		raddr       = cur_q;
		we          = 1'b0;
		waddr       = prev_q;
		wdata       = rd_q;
		out_load    = 1'b0;
		fin_go      = 1'b0;
		fin_idx     = NULL_LINK;
		fin_st      = ST_NOT_FOUND;
		cand_go     = 1'b0;
		cand_f      = head_q;
		cand_steps  = '0;
		cand_cnt    = cnt_q;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					idx_d       = req.chunk_index;
					cnt_d       = req.chunk_count;
					endl_d      = (req.end_link > NULL_LINK) ? NULL_LINK : req.end_link;
					steps_d     = '0;
					prev_head_d = 1'b1;
					unique case (req.kind)
						KIND_ADD: begin
							if (req.chunk_count == '0 ||
							    (10'(req.chunk_index) + 10'(req.chunk_count)) >
							    10'(NUM_CHUNKS)) begin
								fin_go = 1'b1;
								fin_st = ST_INVALID;
							end else begin
								cur_d   = req.chunk_index;
								first_d = req.chunk_index;
								rem_d   = req.chunk_count - CNT_W'(1);
								state_d = S_ADD;
							end
						end
						KIND_FIND: begin
							if (head_q >= NULL_LINK ||
							    head_q > LINK_W'(req.chunk_index)) begin
								fin_go = 1'b1;
							end else begin
								cur_d   = head_q[IDX_W-1:0];
								raddr   = head_q[IDX_W-1:0];
								state_d = S_FIND;
							end
						end
						KIND_ALLOC: begin
							if (req.chunk_count == '0) begin
								fin_go = 1'b1;
								fin_st = ST_INVALID;
							end else begin
								cand_go  = 1'b1;
								cand_f   = head_q;
								cand_cnt = req.chunk_count;
							end
						end
						default: begin
							fin_go = 1'b1;
							fin_st = ST_INVALID;
						end
					endcase
				end
			end
			S_ADD: begin
				we    = 1'b1;
				waddr = cur_q;
				if (rem_q == '0) begin
					wdata   = endl_q;
					head_d  = LINK_W'(first_q);
					fin_go  = 1'b1;
					fin_idx = LINK_W'(first_q);
					fin_st  = ST_OK;
				end else begin
					wdata = LINK_W'(cur_q) + LINK_W'(1);
					cur_d = cur_q + IDX_W'(1);
					rem_d = rem_q - CNT_W'(1);
				end
			end
			S_FIND: begin
				if (rd_q >= NULL_LINK || rd_q > LINK_W'(idx_q)) begin
					fin_go  = 1'b1;
					fin_idx = LINK_W'(cur_q);
					fin_st  = ST_OK;
				end else if (steps_n >= STEP_LIMIT) begin
					fin_go = 1'b1;
				end else begin
					cur_d   = rd_q[IDX_W-1:0];
					raddr   = rd_q[IDX_W-1:0];
					steps_d = steps_n;
				end
			end
			S_WALK: begin
				if (rd_q >= NULL_LINK || rd_q != LINK_W'(cur_q) + LINK_W'(1)) begin
					// run broken: restart the search at the link just read
					prev_d      = cur_q;
					prev_head_d = 1'b0;
					if (steps_n >= STEP_LIMIT) begin
						fin_go = 1'b1;
					end else begin
						cand_go    = 1'b1;
						cand_f     = rd_q;
						cand_steps = steps_n;
					end
				end else begin
					cur_d   = rd_q[IDX_W-1:0];
					raddr   = rd_q[IDX_W-1:0];
					rem_d   = rem_q - CNT_W'(1);
					steps_d = steps_n;
					if (steps_n >= STEP_LIMIT) begin
						fin_go = 1'b1;
					end else if (rem_q == CNT_W'(1)) begin
						state_d = S_TAIL;
					end
				end
			end
			S_TAIL: begin
				// unlink the run: predecessor takes the link after its last chunk
				if (prev_head_q) begin
					head_d = rd_q;
				end else begin
					we    = 1'b1;
					waddr = prev_q;
					wdata = rd_q;
				end
				fin_go  = 1'b1;
				fin_idx = LINK_W'(first_q);
				fin_st  = ST_OK;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cand_go) begin
			if (cand_f >= NULL_LINK) begin
				fin_go = 1'b1;
			end else begin
				first_d = cand_f[IDX_W-1:0];
				cur_d   = cand_f[IDX_W-1:0];
				raddr   = cand_f[IDX_W-1:0];
				rem_d   = cand_cnt - CNT_W'(1);
				steps_d = cand_steps + STEP_W'(1);
				state_d = (cand_cnt == CNT_W'(1)) ? S_TAIL : S_WALK;
			end
		end

		if (fin_go) begin
			res_d   = fin_idx;
			st_d    = fin_st;
			state_d = S_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NULL_LINK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q       <= cur_d;
		first_q     <= first_d;
		prev_q      <= prev_d;
		prev_head_q <= prev_head_d;
		rem_q       <= rem_d;
		cnt_q       <= cnt_d;
		steps_q     <= steps_d;
		idx_q       <= idx_d;
		endl_q      <= endl_d;
		res_q       <= res_d;
		st_q        <= st_d;
		if (out_load) begin
			out_index_q  <= res_q;
			out_status_q <= st_q;
		end
	end

	// writes and the reads that could see them never share a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_index = out_index_q;
	assign rsp.status       = out_status_q;

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_ADD || state_q == S_TAIL))
		else $error("link write outside add or unlink");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND || state_q == S_WALK) |-> (steps_q <= STEP_LIMIT))
		else $error("walk ran past its step limit");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten while stalled");

	a_head_unlink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req.valid) |=> (state_q != S_IDLE))
		else $error("request taken without leaving idle");

endmodule

// File: dv/free_list_chunk_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_chunk_allocator_tb
// Drives add block, find previous and allocate run requests into the
// allocator under random source and sink stalls. A shadow copy of the head
// register and link table predicts each result, and every returned result is
// compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module free_list_chunk_allocator_tb;
	import flca_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CNT_MAX   = (1 << CNT_W) - 1;
	localparam int LINK_MAX  = (1 << LINK_W) - 1;
	localparam int DRAIN_CYC = WALK_LIMIT + 100;
	localparam int PHASE_LEN = 600;

	typedef struct packed {
		logic [LINK_W-1:0]   index;
		logic [STATUS_W-1:0] status;
	} chunk_result_t;

	class free_list_shadow;
		logic [LINK_W-1:0] head;
		logic [LINK_W-1:0] links [NUM_CHUNKS];
		chunk_result_t     expected_results [$];
		int                errors;

		function new();
			head   = NULL_LINK;
			errors = 0;
		endfunction

		// Apply one accepted request to the shadow list and queue its result.
		function void note_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
				logic [CNT_W-1:0] cnt, logic [LINK_W-1:0] endl);
			chunk_result_t r;
			int            it, nx, first, prev, steps, left;
			bit            ok, done;
			r.index  = NULL_LINK;
			r.status = ST_INVALID;
			case (kind)
				KIND_ADD: if (cnt != 0 && int'(idx) + int'(cnt) <= NUM_CHUNKS) begin
					for (int i = 0; i + 1 < int'(cnt); i++)
						links[int'(idx) + i] = LINK_W'(int'(idx) + i + 1);
					links[int'(idx) + int'(cnt) - 1] = (endl > NULL_LINK) ? NULL_LINK : endl;
					head     = LINK_W'(idx);
					r.index  = LINK_W'(idx);
					r.status = ST_OK;
				end
				KIND_FIND: begin
					r.status = ST_NOT_FOUND;
					it       = int'(head);
					steps    = 0;
					// a null head is always beyond any chunk index
					if (it <= int'(idx)) begin
						while (steps < WALK_LIMIT) begin
							nx = int'(links[it]);
							if (nx > int'(idx)) begin
								r.index  = LINK_W'(it);
								r.status = ST_OK;
								break;
							end
							it = nx;
							steps++;
						end
					end
				end
				KIND_ALLOC: if (cnt != 0) begin
					r.status = ST_NOT_FOUND;
					prev     = NUM_CHUNKS;
					steps    = 0;
					done     = 0;
					while (!done && steps < WALK_LIMIT) begin
						first = (prev == NUM_CHUNKS) ? int'(head) : int'(links[prev]);
						if (first >= NUM_CHUNKS)
							break;
						it    = first;
						left  = int'(cnt) - 1;
						ok    = 1;
						steps++;
						while (left != 0) begin
							nx = int'(links[it]);
							steps++;
							if (nx >= NUM_CHUNKS || nx != it + 1) begin
								// restart the search after the chunk that broke the run
								prev = it;
								ok   = 0;
								break;
							end
							it = nx;
							if (steps >= WALK_LIMIT) begin
								ok = 0;
								break;
							end
							left--;
						end
						if (ok) begin
							if (prev == NUM_CHUNKS)
								head = links[it];
							else
								links[prev] = links[it];
							r.index  = LINK_W'(first);
							r.status = ST_OK;
							done     = 1;
						end
					end
				end
				default: ;
			endcase
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [LINK_W-1:0] index, logic [STATUS_W-1:0] status);
			chunk_result_t exp_r;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with nothing pending: index %0d status %0d",
						$realtime, index, status);
				return;
			end
			exp_r = expected_results.pop_front();
			if (index !== exp_r.index || status !== exp_r.status) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch: index exp %0d got %0d, status exp %0d got %0d",
						$realtime, exp_r.index, index, exp_r.status, status);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;

	free_list_shadow tracker;

	flca_req_if req_ch ();
	flca_rsp_if rsp_ch ();

	free_list_chunk_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_result(rsp_ch.result_index, rsp_ch.status);
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
			logic [CNT_W-1:0] cnt, logic [LINK_W-1:0] endl);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.kind        <= kind;
		req_ch.chunk_index <= idx;
		req_ch.chunk_count <= cnt;
		req_ch.end_link    <= endl;
		do
			@(posedge clk);
		while (!req_ch.ready);
		tracker.note_request(kind, idx, cnt, endl);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		int                cnt, endl, pick;
		// unused fields carry noise
		idx  = IDX_W'($urandom_range(0, NUM_CHUNKS - 1));
		cnt  = $urandom_range(0, CNT_MAX);
		endl = $urandom_range(0, LINK_MAX);
		pick = $urandom_range(99);
		if (pick < 38) begin
			kind = KIND_ADD;
			pick = $urandom_range(99);
			if (pick < 4) begin
				// rebuild the whole pool to break up loops
				idx  = '0;
				cnt  = NUM_CHUNKS;
				endl = NUM_CHUNKS;
			end else begin
				if (pick < 70)
					cnt = $urandom_range(1, 8);
				else if (pick < 92)
					cnt = $urandom_range(1, 64);
				else if (pick < 95)
					cnt = 0;
				if (pick < 95 && cnt >= 1)
					idx = IDX_W'($urandom_range(0, NUM_CHUNKS - cnt));
				pick = $urandom_range(99);
				if (pick < 64)
					endl = int'(tracker.head);
				else if (pick < 84)
					endl = NUM_CHUNKS;
				else if (pick < 94)
					endl = $urandom_range(NUM_CHUNKS, LINK_MAX);
				else
					endl = $urandom_range(0, NUM_CHUNKS - 1);
			end
		end else if (pick < 68) begin
			kind = KIND_FIND;
		end else if (pick < 97) begin
			kind = KIND_ALLOC;
			pick = $urandom_range(99);
			if (pick < 60)
				cnt = $urandom_range(1, 3);
			else if (pick < 90)
				cnt = $urandom_range(1, 12);
			else if (pick < 93)
				cnt = 0;
		end else begin
			kind = KIND_UNUSED;
		end
		send_request(kind, idx, CNT_W'(cnt), LINK_W'(endl));
	endtask

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		send_idle_pct      = 0;
		recv_idle_pct      = 0;
		req_ch.valid       = 1'b0;
		req_ch.kind        = KIND_ADD;
		req_ch.chunk_index = '0;
		req_ch.chunk_count = '0;
		req_ch.end_link    = '0;
		rsp_ch.ready       = 1'b0;
		tracker            = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// empty list, rejected requests
		send_request(KIND_FIND, 8'd255, 9'd0, NULL_LINK);
		send_request(KIND_ALLOC, 8'd0, 9'd1, NULL_LINK);
		send_request(KIND_ADD, 8'd10, 9'd0, NULL_LINK);
		send_request(KIND_ALLOC, 8'd0, 9'd0, NULL_LINK);
		send_request(KIND_ADD, 8'd200, 9'd100, NULL_LINK);
		send_request(KIND_ADD, 8'd255, 9'd511, NULL_LINK);
		send_request(KIND_UNUSED, 8'd255, 9'd511, 9'd511);
		// whole pool, then walk it end to end
		send_request(KIND_ADD, 8'd0, 9'd256, NULL_LINK);
		send_request(KIND_FIND, 8'd255, 9'd0, NULL_LINK);
		send_request(KIND_FIND, 8'd0, 9'd0, NULL_LINK);
		send_request(KIND_ALLOC, 8'd0, 9'd256, NULL_LINK);
		send_request(KIND_ALLOC, 8'd0, 9'd1, NULL_LINK);
		// oversized end link, head beyond the queried chunk
		send_request(KIND_ADD, 8'd255, 9'd1, 9'd511);
		send_request(KIND_FIND, 8'd100, 9'd0, NULL_LINK);
		send_request(KIND_ADD, 8'd10, 9'd5, 9'd255);
		send_request(KIND_ALLOC, 8'd0, 9'd3, NULL_LINK);
		send_request(KIND_ALLOC, 8'd0, 9'd511, NULL_LINK);
		send_request(KIND_FIND, 8'd254, 9'd0, NULL_LINK);
		send_request(KIND_ADD, 8'd1, 9'd255, 9'd10);
		send_request(KIND_ALLOC, 8'd0, 9'd2, NULL_LINK);
		// self loop hits the walk limit
		send_request(KIND_ADD, 8'd0, 9'd1, 9'd0);
		send_request(KIND_FIND, 8'd200, 9'd0, NULL_LINK);
		send_request(KIND_ALLOC, 8'd0, 9'd2, NULL_LINK);
		send_request(KIND_ADD, 8'd0, 9'd256, NULL_LINK);

		send_idle_pct = 8;
		recv_idle_pct = 53;
		repeat (PHASE_LEN) send_random();
		send_idle_pct = 53;
		recv_idle_pct = 8;
		repeat (PHASE_LEN) send_random();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (PHASE_LEN) send_random();
		req_ch.valid <= 1'b0;

		while (tracker.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		tracker.errors += tracker.expected_results.size();

		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
